FILE: design/rod_pkg.sv
// Shared types, widths and register indexes of the rectangle overlap and distance unit.
package rod_pkg;

  localparam int COORD_BITS  = 20;
  localparam int NORM_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * COORD_BITS + 1;
  localparam int DOT_W       = 2 * COORD_BITS + 2;
  localparam int MAG_W       = COORD_BITS;
  localparam int SQ_W        = 2 * COORD_BITS + 1;
  localparam int RT_W        = (SQ_W + 1) / 2;
  localparam int DIST_W      = 21;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_AXES    = 8;
  localparam int NUM_PAIRS   = 16;
  localparam int PIPE_DEPTH  = 6 + RT_W;

  localparam logic [CFG_IDX_W-1:0] REG_REF_X0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y0 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REF_X1 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REF_X2 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y2 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_REF_X3 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y3 = CFG_IDX_W'(7);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic [SQ_W-1:0]              sq_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } quad_t;

  typedef struct packed {
    coord_t probe_x0;
    coord_t probe_y0;
    coord_t probe_x1;
    coord_t probe_y1;
    coord_t probe_x2;
    coord_t probe_y2;
    coord_t probe_x3;
    coord_t probe_y3;
  } probe_t;

  typedef struct packed {
    logic              separated;
    logic [DIST_W-1:0] corner_distance;
    logic [1:0]        near_ref_corner;
    logic [1:0]        near_probe_corner;
  } result_t;

  typedef struct packed {
    logic [1:0] ref_idx;
    logic [1:0] probe_idx;
    sq_t        dsq;
  } cand_t;

  typedef struct packed {
    logic       sep;
    logic [1:0] ref_idx;
    logic [1:0] probe_idx;
  } tag_t;

endpackage

FILE: design/rod_axis_lane.sv
// One separating axis: edge normal, projections of both shapes and the gap test.
module rod_axis_lane import rod_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  quad_t  ref_q,
  input  quad_t  prb_q,
  input  coord_t a_x,
  input  coord_t a_y,
  input  coord_t b_x,
  input  coord_t b_y,
  output logic   gap
);

  logic signed [NORM_W-1:0] nx_r, ny_r;
  quad_t ref_a_r, prb_a_r;
  dot_t rdot_r [4];
  dot_t pdot_r [4];
  dot_t rmin_r, rmax_r, pmin_r, pmax_r;
  logic gap_r;

  dot_t rdot_nxt [4];
  dot_t pdot_nxt [4];
  dot_t rmin_nxt, rmax_nxt, pmin_nxt, pmax_nxt;

  always_comb begin
    logic signed [PROD_W-1:0] p0, p1, q0, q1;
    for (int k = 0; k < 4; k++) begin
      p0 = ref_a_r.x[k] * nx_r;
      p1 = ref_a_r.y[k] * ny_r;
      q0 = prb_a_r.x[k] * nx_r;
      q1 = prb_a_r.y[k] * ny_r;
      rdot_nxt[k] = dot_t'(p0) + dot_t'(p1);
      pdot_nxt[k] = dot_t'(q0) + dot_t'(q1);
    end
  end

  always_comb begin
    dot_t r01n, r23n, r01x, r23x, p01n, p23n, p01x, p23x;
    r01n = (rdot_r[1] < rdot_r[0]) ? rdot_r[1] : rdot_r[0];
    r23n = (rdot_r[3] < rdot_r[2]) ? rdot_r[3] : rdot_r[2];
    r01x = (rdot_r[1] > rdot_r[0]) ? rdot_r[1] : rdot_r[0];
    r23x = (rdot_r[3] > rdot_r[2]) ? rdot_r[3] : rdot_r[2];
    p01n = (pdot_r[1] < pdot_r[0]) ? pdot_r[1] : pdot_r[0];
    p23n = (pdot_r[3] < pdot_r[2]) ? pdot_r[3] : pdot_r[2];
    p01x = (pdot_r[1] > pdot_r[0]) ? pdot_r[1] : pdot_r[0];
    p23x = (pdot_r[3] > pdot_r[2]) ? pdot_r[3] : pdot_r[2];
    rmin_nxt = (r23n < r01n) ? r23n : r01n;
    rmax_nxt = (r23x > r01x) ? r23x : r01x;
    pmin_nxt = (p23n < p01n) ? p23n : p01n;
    pmax_nxt = (p23x > p01x) ? p23x : p01x;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r    <= NORM_W'(b_y) - NORM_W'(a_y);
      ny_r    <= NORM_W'(a_x) - NORM_W'(b_x);
      ref_a_r <= ref_q;
      prb_a_r <= prb_q;
      for (int k = 0; k < 4; k++) begin
        rdot_r[k] <= rdot_nxt[k];
        pdot_r[k] <= pdot_nxt[k];
      end
      rmin_r <= rmin_nxt;
      rmax_r <= rmax_nxt;
      pmin_r <= pmin_nxt;
      pmax_r <= pmax_nxt;
      gap_r  <= (rmax_r < pmin_r) || (pmax_r < rmin_r);
    end
  end

  assign gap = gap_r;

endmodule

FILE: design/rod_pair_lane.sv
// One corner pair: absolute differences and squared distance.
module rod_pair_lane import rod_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  coord_t r_x,
  input  coord_t r_y,
  input  coord_t p_x,
  input  coord_t p_y,
  output sq_t    dsq
);

  logic [MAG_W-1:0] mx_r, my_r;
  sq_t dsq_r;
  logic signed [NORM_W-1:0] dx, dy;
  logic [MAG_W-1:0] mx_nxt, my_nxt;
  logic [2*MAG_W-1:0] sx, sy;

  always_comb begin
    dx = NORM_W'(r_x) - NORM_W'(p_x);
    dy = NORM_W'(r_y) - NORM_W'(p_y);
    mx_nxt = dx[NORM_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    my_nxt = dy[NORM_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    sx = mx_r * mx_r;
    sy = my_r * my_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      dsq_r <= SQ_W'(sx) + SQ_W'(sy);
    end
  end

  assign dsq = dsq_r;

endmodule

FILE: design/rod_merge.sv
// Merging stage: nearest corner pair over all pair lanes and the overlap verdict.
module rod_merge import rod_pkg::*; (
  input  logic clk,
  input  logic adv,
  input  sq_t  dsq [NUM_PAIRS],
  input  logic gap [NUM_AXES],
  output sq_t  best_dsq,
  output tag_t best_tag
);

  cand_t lvl_c_r [4];
  cand_t best_d_r;
  sq_t   best_dsq_r;
  tag_t  best_tag_r;

  cand_t lvl_c_nxt [4];
  cand_t best_d_nxt;
  logic  sep_nxt;

  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.dsq < a.dsq) ? b : a;
  endfunction

  always_comb begin
    cand_t leaf [NUM_PAIRS];
    cand_t half [8];
    for (int p = 0; p < NUM_PAIRS; p++) begin
      leaf[p].ref_idx   = 2'(p / 4);
      leaf[p].probe_idx = 2'(p % 4);
      leaf[p].dsq       = dsq[p];
    end
    for (int h = 0; h < 8; h++) half[h] = pick(leaf[2*h], leaf[2*h+1]);
    for (int q = 0; q < 4; q++) lvl_c_nxt[q] = pick(half[2*q], half[2*q+1]);
    best_d_nxt = pick(pick(lvl_c_r[0], lvl_c_r[1]), pick(lvl_c_r[2], lvl_c_r[3]));
    sep_nxt = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) sep_nxt = sep_nxt | gap[a];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int q = 0; q < 4; q++) lvl_c_r[q] <= lvl_c_nxt[q];
      best_d_r             <= best_d_nxt;
      best_dsq_r           <= best_d_r.dsq;
      best_tag_r.sep       <= sep_nxt;
      best_tag_r.ref_idx   <= best_d_r.ref_idx;
      best_tag_r.probe_idx <= best_d_r.probe_idx;
    end
  end

  assign best_dsq = best_dsq_r;
  assign best_tag = best_tag_r;

endmodule

FILE: design/rod_isqrt.sv
// Pipelined integer square root, one result bit per stage, carrying a side tag.
module rod_isqrt import rod_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  sq_t             rad,
  input  tag_t            tag_in,
  output logic [RT_W-1:0] root,
  output tag_t            tag_out
);

  sq_t             rem_r  [RT_W];
  logic [RT_W-1:0] root_r [RT_W];
  tag_t            tag_r  [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    localparam int B = RT_W - 1 - s;
    sq_t             rem_in;
    logic [RT_W-1:0] root_in;
    tag_t            tag_st;
    logic [SQ_W:0]   term;
    sq_t             rem_nxt;
    logic [RT_W-1:0] root_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
      assign tag_st  = tag_in;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign tag_st  = tag_r[s-1];
    end

    always_comb begin
      term = ((SQ_W+1)'(root_in) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
      if ({1'b0, rem_in} >= term) begin
        rem_nxt  = SQ_W'({1'b0, rem_in} - term);
        root_nxt = root_in | (RT_W'(1) << B);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        tag_r[s]  <= tag_st;
      end
    end
  end

  assign root    = root_r[RT_W-1];
  assign tag_out = tag_r[RT_W-1];

endmodule

FILE: design/rectangle_overlap_and_distance_unit.sv
// Top level: reference registers, axis and pair lanes, merge stage and square root pipeline.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | in_data   (probe_t)
//  out_    | output    | out_valid / out_stall | out_data  (result_t)
//  cfg_    | input     | cfg_wr_en             | cfg_index, cfg_data
//
// A new probe transfer is taken every cycle unless a valid output is stalled; each result passes
// through six geometry stages and then the 21-stage square root.
// Reset clears the valid pipeline and the reference corners to zero.
// A stall on a valid output freezes the whole pipeline, and in_stall follows that freeze.
module rectangle_overlap_and_distance_unit import rod_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  probe_t               in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  coord_t               cfg_data
);

  quad_t ref_r, ref_nxt;
  probe_t in_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic adv;
  quad_t prb_q;
  logic gap [NUM_AXES];
  sq_t dsq [NUM_PAIRS];
  sq_t best_dsq;
  tag_t best_tag, fin_tag;
  logic [RT_W-1:0] root;

  assign adv      = !vld_r[PIPE_DEPTH-1] || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    ref_nxt = ref_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_REF_X0: ref_nxt.x[0] = cfg_data;
        REG_REF_Y0: ref_nxt.y[0] = cfg_data;
        REG_REF_X1: ref_nxt.x[1] = cfg_data;
        REG_REF_Y1: ref_nxt.y[1] = cfg_data;
        REG_REF_X2: ref_nxt.x[2] = cfg_data;
        REG_REF_Y2: ref_nxt.y[2] = cfg_data;
        REG_REF_X3: ref_nxt.x[3] = cfg_data;
        REG_REF_Y3: ref_nxt.y[3] = cfg_data;
        default:    ref_nxt = ref_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
      vld_r <= '0;
    end else begin
      ref_r <= ref_nxt;
      if (adv) vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) in_r <= in_data;
  end

  always_comb begin
    prb_q.x[0] = in_r.probe_x0;
    prb_q.y[0] = in_r.probe_y0;
    prb_q.x[1] = in_r.probe_x1;
    prb_q.y[1] = in_r.probe_y1;
    prb_q.x[2] = in_r.probe_x2;
    prb_q.y[2] = in_r.probe_y2;
    prb_q.x[3] = in_r.probe_x3;
    prb_q.y[3] = in_r.probe_y3;
  end

  for (genvar e = 0; e < 4; e++) begin : g_edge
    rod_axis_lane u_ref_axis (
      .clk   (clk),
      .adv   (adv),
      .ref_q (ref_r),
      .prb_q (prb_q),
      .a_x   (ref_r.x[e]),
      .a_y   (ref_r.y[e]),
      .b_x   (ref_r.x[(e+1)%4]),
      .b_y   (ref_r.y[(e+1)%4]),
      .gap   (gap[e])
    );
    rod_axis_lane u_prb_axis (
      .clk   (clk),
      .adv   (adv),
      .ref_q (ref_r),
      .prb_q (prb_q),
      .a_x   (prb_q.x[e]),
      .a_y   (prb_q.y[e]),
      .b_x   (prb_q.x[(e+1)%4]),
      .b_y   (prb_q.y[(e+1)%4]),
      .gap   (gap[e+4])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_ref
    for (genvar j = 0; j < 4; j++) begin : g_prb
      rod_pair_lane u_pair (
        .clk (clk),
        .adv (adv),
        .r_x (ref_r.x[i]),
        .r_y (ref_r.y[i]),
        .p_x (prb_q.x[j]),
        .p_y (prb_q.y[j]),
        .dsq (dsq[i*4+j])
      );
    end
  end

  rod_merge u_merge (
    .clk      (clk),
    .adv      (adv),
    .dsq      (dsq),
    .gap      (gap),
    .best_dsq (best_dsq),
    .best_tag (best_tag)
  );

  rod_isqrt u_isqrt (
    .clk     (clk),
    .adv     (adv),
    .rad     (best_dsq),
    .tag_in  (best_tag),
    .root    (root),
    .tag_out (fin_tag)
  );

  assign out_valid                  = vld_r[PIPE_DEPTH-1];
  assign out_data.separated         = fin_tag.sep;
  assign out_data.corner_distance   = fin_tag.sep ? DIST_W'(root) : '0;
  assign out_data.near_ref_corner   = fin_tag.sep ? fin_tag.ref_idx : 2'b00;
  assign out_data.near_probe_corner = fin_tag.sep ? fin_tag.probe_idx : 2'b00;

endmodule
